FILE: hdl/cpsc_pkg.sv
// package for the charge port session controller
// shared types, codes and register reset values; no dependencies
package cpsc_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_PULSE = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STOP_NONE   = 2'd0,
        STOP_BUDGET = 2'd1,
        STOP_TIME   = 2'd2,
        STOP_CMD    = 2'd3
    } reason_t;

    typedef enum logic [1:0] {
        ALARM_NONE     = 2'd0,
        ALARM_OVERLOAD = 2'd1,
        ALARM_FULL     = 2'd2
    } alarm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLOAD_GAP    = 3'd0,
        REG_FULL_GAP        = 3'd1,
        REG_OVERLOAD_LIMIT  = 3'd2,
        REG_FULL_LIMIT      = 3'd3,
        REG_PULSES_PER_COIN = 3'd4,
        REG_TICKS_PER_COIN  = 3'd5,
        REG_REPORT_INTERVAL = 3'd6
    } cfg_reg_t;

    localparam logic [15:0] RST_OVERLOAD_GAP    = 16'd100;
    localparam logic [15:0] RST_FULL_GAP        = 16'd10000;
    localparam logic [7:0]  RST_OVERLOAD_LIMIT  = 8'd5;
    localparam logic [7:0]  RST_FULL_LIMIT      = 8'd5;
    localparam logic [15:0] RST_PULSES_PER_COIN = 16'd100;
    localparam logic [23:0] RST_TICKS_PER_COIN  = 24'd3600000;
    localparam logic [7:0]  RST_REPORT_INTERVAL = 8'd10;

    typedef struct packed {
        logic [15:0] overload_gap;
        logic [15:0] full_gap;
        logic [7:0]  overload_limit;
        logic [7:0]  full_limit;
        logic [15:0] pulses_per_coin;
        logic [23:0] ticks_per_coin;
        logic [7:0]  report_interval;
    } cfg_t;

    typedef struct packed {
        action_t    action;
        logic       online;
        logic [7:0] coins_paid;
    } item_t;

    typedef struct packed {
        alarm_t      pulse_alarm;
        reason_t     stop_reason;
        logic [31:0] consumed;
        logic        report_final;
        logic        report_valid;
        logic        busy_res;
        logic        relay_on;
    } result_t;

endpackage

FILE: hdl/cpsc_cfg_regs.sv
// configuration register file for the charge port session controller
// depends on cpsc_pkg
module cpsc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpsc_pkg::CFG_W-1:0]     cfg_data,
    output cpsc_pkg::cfg_t                cfg
);
    import cpsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_OVERLOAD_GAP:    cfg_next.overload_gap    = cfg_data[15:0];
                REG_FULL_GAP:        cfg_next.full_gap        = cfg_data[15:0];
                REG_OVERLOAD_LIMIT:  cfg_next.overload_limit  = cfg_data[7:0];
                REG_FULL_LIMIT:      cfg_next.full_limit      = cfg_data[7:0];
                REG_PULSES_PER_COIN: cfg_next.pulses_per_coin = cfg_data[15:0];
                REG_TICKS_PER_COIN:  cfg_next.ticks_per_coin  = cfg_data[23:0];
                REG_REPORT_INTERVAL: cfg_next.report_interval = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overload_gap    <= RST_OVERLOAD_GAP;
            cfg_reg.full_gap        <= RST_FULL_GAP;
            cfg_reg.overload_limit  <= RST_OVERLOAD_LIMIT;
            cfg_reg.full_limit      <= RST_FULL_LIMIT;
            cfg_reg.pulses_per_coin <= RST_PULSES_PER_COIN;
            cfg_reg.ticks_per_coin  <= RST_TICKS_PER_COIN;
            cfg_reg.report_interval <= RST_REPORT_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/cpsc_core.sv
// session state and single-pass item logic of the charge port session controller
// depends on cpsc_pkg
module cpsc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  cpsc_pkg::item_t   item,
    input  cpsc_pkg::cfg_t    cfg,
    output cpsc_pkg::result_t result
);
    import cpsc_pkg::*;

    logic [31:0] now_ticks_reg,   now_ticks_next;
    logic [31:0] last_pulse_reg,  last_pulse_next;
    logic [7:0]  short_count_reg, short_count_next;
    logic [7:0]  long_count_reg,  long_count_next;
    logic [31:0] pulse_total_reg, pulse_total_next;
    logic [7:0]  report_count_reg, report_count_next;
    logic        active_reg,      active_next;
    logic        online_reg,      online_next;
    logic [23:0] budget_reg,      budget_next;
    logic [31:0] time_left_reg,   time_left_next;

    logic [31:0] gap;
    logic [31:0] time_dec;
    logic [31:0] total_inc;
    logic [7:0]  short_inc;
    logic [7:0]  long_inc;
    logic [7:0]  report_inc;
    logic [23:0] budget_prod;
    logic [31:0] time_prod;
    logic        end_req;
    reason_t     end_reason;
    logic [31:0] end_count;

    assign gap         = now_ticks_reg - last_pulse_reg;
    assign time_dec    = time_left_reg - 32'd1;
    assign total_inc   = pulse_total_reg + 32'd1;
    assign short_inc   = short_count_reg + 8'd1;
    assign long_inc    = long_count_reg + 8'd1;
    assign report_inc  = report_count_reg + 8'd1;
    assign budget_prod = {16'd0, item.coins_paid} * {8'd0, cfg.pulses_per_coin};
    assign time_prod   = {24'd0, item.coins_paid} * {8'd0, cfg.ticks_per_coin};

    always_comb
    begin
        now_ticks_next    = now_ticks_reg;
        last_pulse_next   = last_pulse_reg;
        short_count_next  = short_count_reg;
        long_count_next   = long_count_reg;
        pulse_total_next  = pulse_total_reg;
        report_count_next = report_count_reg;
        active_next       = active_reg;
        online_next       = online_reg;
        budget_next       = budget_reg;
        time_left_next    = time_left_reg;
        end_req           = 1'b0;
        end_reason        = STOP_NONE;
        end_count         = pulse_total_reg;
        result            = '0;

        case (item.action)
            ACT_TICK:
            begin
                now_ticks_next = now_ticks_reg + 32'd1;
                if (active_reg && !online_reg && (time_left_reg != 32'd0))
                begin
                    time_left_next = time_dec;
                    if (time_dec == 32'd0)
                    begin
                        end_req    = 1'b1;
                        end_reason = STOP_TIME;
                    end
                end
            end
            ACT_PULSE:
            begin
                if (gap < {16'd0, cfg.overload_gap})
                begin
                    if (short_inc > cfg.overload_limit)
                    begin
                        result.pulse_alarm = ALARM_OVERLOAD;
                        short_count_next   = 8'd0;
                    end
                    else
                    begin
                        short_count_next = short_inc;
                    end
                end
                else if (gap > {16'd0, cfg.full_gap})
                begin
                    if (long_inc > cfg.full_limit)
                    begin
                        result.pulse_alarm = ALARM_FULL;
                        long_count_next    = 8'd0;
                    end
                    else
                    begin
                        long_count_next = long_inc;
                    end
                end
                else
                begin
                    short_count_next = 8'd0;
                    long_count_next  = 8'd0;
                end
                last_pulse_next = now_ticks_reg;
                if (active_reg)
                begin
                    pulse_total_next = total_inc;
                    if (!online_reg)
                    begin
                        if (total_inc >= {8'd0, budget_reg})
                        begin
                            end_req    = 1'b1;
                            end_reason = STOP_BUDGET;
                            end_count  = total_inc;
                        end
                    end
                    else if (report_inc >= cfg.report_interval)
                    begin
                        report_count_next   = 8'd0;
                        result.report_valid = 1'b1;
                    end
                    else
                    begin
                        report_count_next = report_inc;
                    end
                end
            end
            ACT_START:
            begin
                active_next      = 1'b1;
                online_next      = item.online;
                pulse_total_next = 32'd0;
                budget_next      = item.online ? 24'd0 : budget_prod;
                time_left_next   = item.online ? 32'd0 : time_prod;
            end
            ACT_STOP:
            begin
                if (active_reg)
                begin
                    end_req    = 1'b1;
                    end_reason = STOP_CMD;
                end
            end
            default:
            begin
                end_req = 1'b0;
            end
        endcase

        if (end_req)
        begin
            if (online_reg)
            begin
                result.report_valid = 1'b1;
                result.report_final = 1'b1;
            end
            result.consumed    = end_count;
            result.stop_reason = end_reason;
            active_next        = 1'b0;
            online_next        = 1'b0;
            budget_next        = 24'd0;
            time_left_next     = 32'd0;
            pulse_total_next   = 32'd0;
        end

        result.relay_on = active_next;
        result.busy_res = active_next;
        if (active_next)
        begin
            result.consumed = pulse_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ticks_reg    <= '0;
            last_pulse_reg   <= '0;
            short_count_reg  <= '0;
            long_count_reg   <= '0;
            pulse_total_reg  <= '0;
            report_count_reg <= '0;
            active_reg       <= 1'b0;
            online_reg       <= 1'b0;
            budget_reg       <= '0;
            time_left_reg    <= '0;
        end
        else if (advance)
        begin
            now_ticks_reg    <= now_ticks_next;
            last_pulse_reg   <= last_pulse_next;
            short_count_reg  <= short_count_next;
            long_count_reg   <= long_count_next;
            pulse_total_reg  <= pulse_total_next;
            report_count_reg <= report_count_next;
            active_reg       <= active_next;
            online_reg       <= online_next;
            budget_reg       <= budget_next;
            time_left_reg    <= time_left_next;
        end
    end

endmodule

FILE: hdl/charge_port_session_controller_unit.sv
// charge port session controller, top level
// input register, result register and handshake; uses cpsc_pkg, cpsc_cfg_regs, cpsc_core
//
// usage
//   s_* channel takes one item per transfer: tick, meter pulse, start or stop
//   m_* channel returns exactly one result per item, in order
//   cfg_we/cfg_index/cfg_data write one register per cycle, only while idle
// datapath
//   an item waits in the input register, then the session logic writes its
//   result into the result register, which drives the m_* channel
// throughput
//   one item per cycle while m_tready is high, set by the single pass of the
//   session logic between the input register and the result register
// reset
//   rst_n clears both pipeline valids, the session state and the counters, and
//   loads the register defaults; the port comes up free with the relay off
// stall
//   while m_tready is low the result register holds; one more item may wait in
//   the input register, after which s_tready drops until the result is taken
module charge_port_session_controller_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpsc_pkg::CFG_W-1:0]     cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // online [0], coins_paid [8:1]
    input  logic [1:0]                    s_tuser,  // action [1:0]
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata   // relay_on [0], busy_res [1],
                                                    // report_valid [2], report_final [3],
                                                    // consumed [35:4], stop_reason [37:36],
                                                    // pulse_alarm [39:38]
);
    import cpsc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_data_reg;
    logic    out_valid_reg;
    result_t core_result;
    logic    advance;
    logic    in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    cpsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.action     <= action_t'(s_tuser);
            in_item_reg.online     <= s_tdata[0];
            in_item_reg.coins_paid <= s_tdata[8:1];
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a final report always comes with a report
    a_final_has_report : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("final report without report flag");

    // a result that ends a session leaves the relay off and the port free
    a_stop_frees_port : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[37:36] != STOP_NONE) |-> !m_tdata[0] && !m_tdata[1])
        else $error("stop reason with relay still on");

    // relay drive and busy state always agree
    a_relay_busy : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == m_tdata[1]))
        else $error("relay and busy disagree");

    // an item waiting behind a stalled result is not lost
    a_hold_item : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending item dropped during stall");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// testbench for the charge port session controller: directed table, then random phases
// predicts every result in step with the transfers; depends on cpsc_pkg and the unit
module tb_top;
    import cpsc_pkg::*;

    typedef struct packed {
        action_t    act;
        logic       online;
        logic [7:0] coins;
        logic       typed;
        result_t    res;
    } dir_row_t;

    localparam result_t RES_FREE     = '{ALARM_NONE, STOP_NONE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam result_t RES_CHARGING = '{ALARM_NONE, STOP_NONE, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam result_t RES_SPENT    = '{ALARM_NONE, STOP_BUDGET, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam int ITEMS_PER_PHASE   = 330;
    localparam int HOLD_CYCLES       = 60;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;

    charge_port_session_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // outlet model state
    cfg_t        outlet_cfg;
    logic [31:0] tick_clock;
    logic [31:0] last_pulse_at;
    logic [7:0]  short_run;
    logic [7:0]  long_run;
    logic [31:0] session_pulses;
    logic [7:0]  report_count;
    logic        charging;
    logic        card_session;
    logic [31:0] pulse_allowance;
    logic [31:0] ticks_left;

    result_t     expected_outlet_results[$];
    result_t     got_res;
    result_t     want_res;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_req;
    cfg_t        phase_cfgs [6];
    dir_row_t    directed_rows [24];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("timeout at %0t with %0d results outstanding", $time,
                 expected_outlet_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic reset_outlet_model;
        outlet_cfg      = '{RST_OVERLOAD_GAP, RST_FULL_GAP, RST_OVERLOAD_LIMIT, RST_FULL_LIMIT,
                            RST_PULSES_PER_COIN, RST_TICKS_PER_COIN, RST_REPORT_INTERVAL};
        tick_clock      = '0;
        last_pulse_at   = '0;
        short_run       = '0;
        long_run        = '0;
        session_pulses  = '0;
        report_count    = '0;
        charging        = 1'b0;
        card_session    = 1'b0;
        pulse_allowance = '0;
        ticks_left      = '0;
    endtask

    function automatic void close_session(inout result_t r, input reason_t why);
        if (card_session)
        begin
            r.report_valid = 1'b1;
            r.report_final = 1'b1;
        end
        r.consumed      = session_pulses;
        r.stop_reason   = why;
        charging        = 1'b0;
        card_session    = 1'b0;
        pulse_allowance = '0;
        ticks_left      = '0;
        session_pulses  = '0;
    endfunction

    function automatic result_t predict_outlet(item_t it);
        result_t     r;
        logic [31:0] gap;
        r = RES_FREE;
        case (it.action)
            ACT_TICK:
            begin
                tick_clock = tick_clock + 32'd1;
                if (charging && !card_session && ticks_left != 0)
                begin
                    ticks_left = ticks_left - 32'd1;
                    if (ticks_left == 0)
                        close_session(r, STOP_TIME);
                end
            end
            ACT_PULSE:
            begin
                gap = tick_clock - last_pulse_at;
                if (gap < {16'd0, outlet_cfg.overload_gap})
                begin
                    short_run = short_run + 8'd1;
                    if (short_run > outlet_cfg.overload_limit)
                    begin
                        r.pulse_alarm = ALARM_OVERLOAD;
                        short_run     = '0;
                    end
                end
                else if (gap > {16'd0, outlet_cfg.full_gap})
                begin
                    long_run = long_run + 8'd1;
                    if (long_run > outlet_cfg.full_limit)
                    begin
                        r.pulse_alarm = ALARM_FULL;
                        long_run      = '0;
                    end
                end
                else
                begin
                    short_run = '0;
                    long_run  = '0;
                end
                last_pulse_at = tick_clock;
                if (charging)
                begin
                    session_pulses = session_pulses + 32'd1;
                    if (!card_session)
                    begin
                        if (session_pulses >= pulse_allowance)
                            close_session(r, STOP_BUDGET);
                    end
                    else
                    begin
                        report_count = report_count + 8'd1;
                        if (report_count >= outlet_cfg.report_interval)
                        begin
                            report_count   = '0;
                            r.report_valid = 1'b1;
                        end
                    end
                end
            end
            ACT_START:
            begin
                charging       = 1'b1;
                card_session   = it.online;
                session_pulses = '0;
                if (it.online)
                begin
                    pulse_allowance = '0;
                    ticks_left      = '0;
                end
                else
                begin
                    pulse_allowance = {24'd0, it.coins_paid} * {16'd0, outlet_cfg.pulses_per_coin};
                    ticks_left      = {24'd0, it.coins_paid} * {8'd0, outlet_cfg.ticks_per_coin};
                end
            end
            default:
            begin
                if (charging)
                    close_session(r, STOP_CMD);
            end
        endcase
        r.relay_on = charging;
        r.busy_res = charging;
        if (charging)
            r.consumed = session_pulses;
        return r;
    endfunction

    // one transfer on the input side; the typed result replaces the prediction where given
    task automatic send_item(item_t it, logic typed, result_t typed_res);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {7'd0, it.coins_paid, it.online};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_outlet(it);
        expected_outlet_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic send_random;
        item_t       it;
        int unsigned pick;
        int unsigned run;
        pick          = $urandom_range(0, 99);
        it.online     = 1'($urandom_range(0, 1));
        it.coins_paid = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 3));
        if (pick < 12)
        begin
            run       = $urandom_range(2, 14);
            it.action = ACT_TICK;
            repeat (run)
                send_item(it, 1'b0, RES_FREE);
        end
        else
        begin
            if (pick < 45)
                it.action = ACT_TICK;
            else if (pick < 86)
                it.action = ACT_PULSE;
            else if (pick < 96)
                it.action = ACT_START;
            else
                it.action = ACT_STOP;
            send_item(it, 1'b0, RES_FREE);
        end
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_outlet_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_config(cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_OVERLOAD_GAP;
        cfg_data  <= {8'd0, c.overload_gap};
        @(posedge clk);
        cfg_index <= REG_FULL_GAP;
        cfg_data  <= {8'd0, c.full_gap};
        @(posedge clk);
        cfg_index <= REG_OVERLOAD_LIMIT;
        cfg_data  <= {16'd0, c.overload_limit};
        @(posedge clk);
        cfg_index <= REG_FULL_LIMIT;
        cfg_data  <= {16'd0, c.full_limit};
        @(posedge clk);
        cfg_index <= REG_PULSES_PER_COIN;
        cfg_data  <= {8'd0, c.pulses_per_coin};
        @(posedge clk);
        cfg_index <= REG_TICKS_PER_COIN;
        cfg_data  <= c.ticks_per_coin;
        @(posedge clk);
        cfg_index <= REG_REPORT_INTERVAL;
        cfg_data  <= {16'd0, c.report_interval};
        @(posedge clk);
        cfg_we     <= 1'b0;
        outlet_cfg  = c;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: compare every transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = result_t'(m_tdata);
            if (expected_outlet_results.size() == 0)
            begin
                $display("%0t: result %0h with nothing expected", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want_res = expected_outlet_results.pop_front();
                check_field("relay_on", want_res.relay_on, got_res.relay_on);
                check_field("busy_res", want_res.busy_res, got_res.busy_res);
                check_field("report_valid", want_res.report_valid, got_res.report_valid);
                check_field("report_final", want_res.report_final, got_res.report_final);
                check_field("consumed", want_res.consumed, got_res.consumed);
                check_field("stop_reason", want_res.stop_reason, got_res.stop_reason);
                check_field("pulse_alarm", want_res.pulse_alarm, got_res.pulse_alarm);
            end
            results_checked++;
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        item_t it;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_OVERLOAD_GAP;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = ACT_TICK;
        hold_req        = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        send_idle_pct   = 32;
        recv_idle_pct   = 76;
        reset_outlet_model();

        directed_rows = '{
            '{ACT_TICK,  1'b0, 8'd0,   1'b1, RES_FREE},
            '{ACT_STOP,  1'b0, 8'd0,   1'b1, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b1, RES_FREE},
            '{ACT_START, 1'b0, 8'd0,   1'b1, RES_CHARGING},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b1, RES_SPENT},
            '{ACT_START, 1'b1, 8'd255, 1'b0, RES_FREE},
            '{ACT_PULSE, 1'b1, 8'd0,   1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd255, 1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_START, 1'b0, 8'd255, 1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_TICK,  1'b1, 8'd255, 1'b0, RES_FREE},
            '{ACT_TICK,  1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_STOP,  1'b1, 8'd255, 1'b0, RES_FREE},
            '{ACT_START, 1'b1, 8'd0,   1'b0, RES_FREE},
            '{ACT_PULSE, 1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_STOP,  1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_STOP,  1'b0, 8'd0,   1'b1, RES_FREE},
            '{ACT_TICK,  1'b0, 8'd0,   1'b0, RES_FREE},
            '{ACT_START, 1'b0, 8'h55,  1'b0, RES_FREE},
            '{ACT_TICK,  1'b0, 8'hAA,  1'b0, RES_FREE},
            '{ACT_STOP,  1'b0, 8'd0,   1'b0, RES_FREE}
        };

        // phases 0, 2, 4: small gaps and budgets, so alarms, timeouts, reports come often
        phase_cfgs[0] = '{16'd2, 16'd6, 8'd1, 8'd1, 16'd3, 24'd8, 8'd2};
        phase_cfgs[1] = '{16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 24'd0, 8'd0};
        phase_cfgs[2] = '{16'd4, 16'd1, 8'd0, 8'd2, 16'd1, 24'd5, 8'd1};
        phase_cfgs[3] = '{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 8'hFF};
        phase_cfgs[4] = '{16'd1, 16'd3, 8'd3, 8'd0, 16'd7, 24'd20, 8'd4};
        phase_cfgs[5] = '{RST_OVERLOAD_GAP, RST_FULL_GAP, RST_OVERLOAD_LIMIT, RST_FULL_LIMIT,
                          RST_PULSES_PER_COIN, RST_TICKS_PER_COIN, RST_REPORT_INTERVAL};

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            it.action     = directed_rows[i].act;
            it.online     = directed_rows[i].online;
            it.coins_paid = directed_rows[i].coins;
            send_item(it, directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_config(phase_cfgs[p]);
            if (p < 2)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 76;
            end
            else if (p < 4)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 4)
                hold_req = 1'b1;
            while (items_sent < 24 + ITEMS_PER_PHASE * (p + 1))
                send_random();
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        $display("%0d items sent over 7 register settings, %0d results checked",
                 items_sent, results_checked);
        $display("covered ticks, meter pulses, card and coin sessions, restarts and stops");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
